// ===== rtl/refcounted_page_allocator_top_macros.svh =====
// Assertion macros used by the checker of this block.
// Both expect signals named clk and rst in the scope of use.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_TOP_MACROS_SVH

// consequent checked on the same edge as the antecedent
`define RCPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked on the edge that follows the antecedent
`define RCPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rcpa_pkg.sv =====
package rcpa_pkg;

  localparam int PAGE_W = 15;
  typedef logic [PAGE_W-1:0] page_t;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ALLOC   = 2'd0;
  localparam cmd_t CMD_FREE    = 2'd1;
  localparam cmd_t CMD_ADD_REF = 2'd2;
  localparam cmd_t CMD_COW     = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK     = 3'd0;
  localparam status_t ST_EMPTY  = 3'd1;
  localparam status_t ST_RANGE  = 3'd2;
  localparam status_t ST_DOUBLE = 3'd3;
  localparam status_t ST_SAT    = 3'd4;

  localparam int APB_ADDR_W = 2;
  typedef logic [APB_ADDR_W-1:0] apb_addr_t;
  localparam apb_addr_t ADDR_FIRST_USABLE = 2'd0;

  typedef struct packed {
    cmd_t  cmd;
    page_t page;
  } core_req_t;

  typedef struct packed {
    logic    valid;
    page_t   result_page;
    status_t status;
    logic    page_released;
    logic    needs_copy;
  } core_rsp_t;

endpackage

// ===== rtl/rcpa_in_if.sv =====
interface rcpa_in_if;
  import rcpa_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  cmd;
  page_t page;

  modport source (output valid, output cmd, output page, input ready);
  modport sink (input valid, input cmd, input page, output ready);
endinterface

// ===== rtl/rcpa_out_if.sv =====
interface rcpa_out_if;
  import rcpa_pkg::*;

  logic    valid;
  logic    ready;
  page_t   result_page;
  status_t status;
  logic    page_released;
  logic    needs_copy;

  modport source (output valid, output result_page, output status,
                  output page_released, output needs_copy, input ready);
  modport sink (input valid, input result_page, input status,
                input page_released, input needs_copy, output ready);
endinterface

// ===== rtl/refcounted_page_allocator_top.sv =====
// Channel  Dir  Beat carries                                      Handshake
// req      in   cmd, page                                         valid/ready
// rsp      out  result_page, status, page_released, needs_copy    valid/ready
// apb      in   first_usable_page at byte address 0               psel/penable
//
// One command at a time: from accept to result a command steps through the
// states it needs, which share the count and stack memories and the one
// shared incrementer. After rst a clearing pass zeroes the count memory
// with req.ready low. A result waits in the output register while rsp
// stalls; the next command is accepted meanwhile and holds in its last step.
module refcounted_page_allocator_top #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  rcpa_in_if.sink             req,
  rcpa_out_if.source          rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  rcpa_pkg::apb_addr_t paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rcpa_pkg::*;

  page_t     first_usable;
  logic      core_idle;
  logic      core_load;
  core_req_t core_req;
  core_rsp_t core_rsp;

  logic    out_valid;
  page_t   out_page;
  status_t out_status;
  logic    out_rel;
  logic    out_copy;

  // single register, so every write lands on it
  always_ff @(posedge clk) begin
    if (rst) begin
      first_usable <= '0;
    end else if (psel && penable && pwrite) begin
      first_usable <= pwdata[PAGE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FIRST_USABLE) ? 32'(first_usable) : '0;

  assign core_req.cmd  = req.cmd;
  assign core_req.page = req.page;
  assign req.ready     = core_idle;

  rcpa_core #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .first_usable (first_usable),
    .start        (req.valid && core_idle),
    .req          (core_req),
    .idle         (core_idle),
    .rsp          (core_rsp),
    .rsp_ready    (core_load)
  );

  assign core_load = core_rsp.valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_load) begin
      out_page   <= core_rsp.result_page;
      out_status <= core_rsp.status;
      out_rel    <= core_rsp.page_released;
      out_copy   <= core_rsp.needs_copy;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.result_page   = out_page;
  assign rsp.status        = out_status;
  assign rsp.page_released = out_rel;
  assign rsp.needs_copy    = out_copy;

endmodule

// ===== rtl/rcpa_core.sv =====
module rcpa_core #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  rcpa_pkg::page_t     first_usable,
  input  logic                start,
  input  rcpa_pkg::core_req_t req,
  output logic                idle,
  output rcpa_pkg::core_rsp_t rsp,
  input  logic                rsp_ready
);
  import rcpa_pkg::*;

  localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int SW    = $clog2(NUM_PAGES + 1);
  localparam int AW    = (COUNT_BITS > SW) ? COUNT_BITS : SW;

  localparam logic [COUNT_BITS-1:0] CNT_MAX    = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE    = COUNT_BITS'(1);
  localparam logic [SW-1:0]         DEPTH_FULL = SW'(NUM_PAGES);
  localparam logic [IDX_W-1:0]      IDX_LAST   = IDX_W'(NUM_PAGES - 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CNT    = 4'd2;
  localparam logic [3:0] S_TAKE   = 4'd3;
  localparam logic [3:0] S_POP    = 4'd4;
  localparam logic [3:0] S_SETCNT = 4'd5;
  localparam logic [3:0] S_DEC    = 4'd6;
  localparam logic [3:0] S_PUSH   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state, state_next;

  cmd_t                  cmd_q;
  page_t                 page_q;
  logic [IDX_W-1:0]      pg;
  logic [COUNT_BITS-1:0] saved_cnt;
  logic                  cow;
  logic [SW-1:0]         depth;
  logic [SW-1:0]         fresh;
  logic [IDX_W-1:0]      clr_addr;

  page_t   res_page;
  status_t res_status;
  logic    res_rel;
  logic    res_copy;

  logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
  logic [COUNT_BITS-1:0] cnt_rd;
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [IDX_W-1:0]      cnt_raddr;

  logic [IDX_W-1:0] stack_mem [NUM_PAGES];
  logic [IDX_W-1:0] stack_rd;
  logic             stack_we;
  logic [IDX_W-1:0] stack_raddr;

  // shared incrementer/decrementer
  logic [AW-1:0] alu_a, alu_y;
  logic          alu_dec;

  logic [IDX_W-1:0] req_idx, page_idx;
  logic cnt_zero, cnt_one, cnt_full, stack_some, fresh_some, push_ok;
  logic out_range, same_page, dec_zero;

  assign req_idx    = IDX_W'(32'(req.page));
  assign page_idx   = IDX_W'(32'(page_q));
  assign cnt_zero   = (cnt_rd == '0);
  assign cnt_one    = (cnt_rd == CNT_ONE);
  assign cnt_full   = (cnt_rd == CNT_MAX);
  assign stack_some = (depth != '0);
  assign fresh_some = (32'(fresh) > 32'(first_usable));
  assign push_ok    = (depth != DEPTH_FULL);
  assign out_range  = (32'(req.page) < 32'(first_usable)) ||
                      (32'(req.page) >= 32'(NUM_PAGES));
  assign same_page  = (32'(pg) == 32'(page_q));
  assign dec_zero   = (alu_y == '0);

  always_comb begin
    alu_a   = '0;
    alu_dec = 1'b1;
    unique case (state)
      S_CLEAR: begin
        alu_a   = AW'(clr_addr);
        alu_dec = 1'b0;
      end
      S_CNT: begin
        alu_a   = AW'(cnt_rd);
        alu_dec = (cmd_q == CMD_FREE);
      end
      S_TAKE: alu_a = stack_some ? AW'(depth) : AW'(fresh);
      S_DEC:  alu_a = AW'(saved_cnt);
      S_PUSH: begin
        alu_a   = AW'(depth);
        alu_dec = 1'b0;
      end
      default: ;
    endcase
  end

  assign alu_y = alu_dec ? (alu_a - AW'(1)) : (alu_a + AW'(1));

  // memory port controls
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = page_idx;
    cnt_wdata = alu_y[COUNT_BITS-1:0];
    unique case (state)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr;
        cnt_wdata = '0;
      end
      S_CNT: begin
        if (cmd_q == CMD_FREE) begin
          cnt_we = !cnt_zero;
        end else if (cmd_q == CMD_ADD_REF) begin
          cnt_we = !cnt_full;
        end
      end
      S_SETCNT: begin
        cnt_we    = 1'b1;
        cnt_waddr = pg;
        cnt_wdata = CNT_ONE;
      end
      S_DEC: begin
        // new page may be the old one: it was just set to one, so it drops to zero
        cnt_we = 1'b1;
        if (same_page) begin
          cnt_wdata = '0;
        end
      end
      default: ;
    endcase
  end

  assign cnt_raddr   = (state == S_IDLE) ? req_idx : page_idx;
  assign stack_we    = (state == S_PUSH) && push_ok;
  assign stack_raddr = alu_y[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[depth[IDX_W-1:0]] <= page_idx;
    end
    stack_rd <= stack_mem[stack_raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == IDX_LAST) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (req.cmd == CMD_ALLOC) begin
            state_next = S_TAKE;
          end else if (out_range) begin
            state_next = S_DONE;
          end else begin
            state_next = S_CNT;
          end
        end
      end
      S_CNT: begin
        unique case (cmd_q)
          CMD_FREE:    state_next = (!cnt_zero && dec_zero) ? S_PUSH : S_DONE;
          CMD_COW:     state_next = (cnt_zero || cnt_one) ? S_DONE : S_TAKE;
          CMD_ADD_REF: state_next = S_DONE;
          CMD_ALLOC:   state_next = S_DONE;
        endcase
      end
      S_TAKE: begin
        if (stack_some) begin
          state_next = S_POP;
        end else if (fresh_some) begin
          state_next = S_SETCNT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_POP:    state_next = S_SETCNT;
      S_SETCNT: state_next = cow ? S_DEC : S_DONE;
      S_DEC:    state_next = S_DONE;
      S_PUSH:   state_next = S_DONE;
      S_DONE:   if (rsp_ready) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      depth    <= '0;
      fresh    <= SW'(NUM_PAGES);
      cow      <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr_addr <= alu_y[IDX_W-1:0];
        S_IDLE: begin
          if (start) begin
            cmd_q      <= req.cmd;
            page_q     <= req.page;
            cow        <= 1'b0;
            res_page   <= '0;
            res_status <= (req.cmd != CMD_ALLOC && out_range) ? ST_RANGE : ST_OK;
            res_rel    <= 1'b0;
            res_copy   <= 1'b0;
          end
        end
        S_CNT: begin
          unique case (cmd_q)
            CMD_FREE: begin
              if (cnt_zero) begin
                res_status <= ST_DOUBLE;
              end else if (dec_zero) begin
                res_rel <= 1'b1;
              end
            end
            CMD_ADD_REF: if (cnt_full) res_status <= ST_SAT;
            CMD_COW: begin
              if (cnt_zero) begin
                res_status <= ST_DOUBLE;
              end else if (cnt_one) begin
                res_page <= page_q;
              end else begin
                saved_cnt <= cnt_rd;
                cow       <= 1'b1;
              end
            end
            CMD_ALLOC: ;
          endcase
        end
        S_TAKE: begin
          if (stack_some) begin
            depth <= alu_y[SW-1:0];
          end else if (fresh_some) begin
            fresh <= alu_y[SW-1:0];
            pg    <= alu_y[IDX_W-1:0];
          end else begin
            res_status <= ST_EMPTY;
          end
        end
        S_POP: pg <= stack_rd;
        S_SETCNT: begin
          res_page <= PAGE_W'(32'(pg));
          res_copy <= cow;
        end
        S_PUSH: if (push_ok) depth <= alu_y[SW-1:0];
        default: ;
      endcase
    end
  end

  assign idle              = (state == S_IDLE);
  assign rsp.valid         = (state == S_DONE);
  assign rsp.result_page   = res_page;
  assign rsp.status        = res_status;
  assign rsp.page_released = res_rel;
  assign rsp.needs_copy    = res_copy;

endmodule

// ===== rtl/rcpa_checker.sv =====
`include "refcounted_page_allocator_top_macros.svh"

module rcpa_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input rcpa_pkg::page_t   result_page,
  input rcpa_pkg::status_t status,
  input logic              page_released,
  input logic              needs_copy
);
  import rcpa_pkg::*;

  // a failed command leaves no page and no side flags
  `RCPA_ASSERT_SAME(a_err_clean, rsp_valid && status != ST_OK, result_page == '0 && !page_released && !needs_copy, "failed command carries a page or flag")

  // a free gives back no page and never asks for a copy
  `RCPA_ASSERT_SAME(a_release_only, rsp_valid && page_released, status == ST_OK && !needs_copy && result_page == '0, "released beat carries other results")

  // one command at a time
  `RCPA_ASSERT_NEXT(a_one_busy, req_valid && req_ready, !req_ready, "ready stayed high after an accept")

  // clearing pass follows reset
  `RCPA_ASSERT_SAME(a_clear_after_rst, $past(rst), !req_ready, "ready high straight after reset")

  `RCPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(result_page) && $stable(status), "stalled result changed")

endmodule

bind refcounted_page_allocator_top rcpa_checker u_rcpa_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .result_page   (rsp.result_page),
  .status        (rsp.status),
  .page_released (rsp.page_released),
  .needs_copy    (rsp.needs_copy)
);

// ===== dv/tb_refcounted_page_allocator_top.sv =====
module tb_refcounted_page_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcpa_pkg::*;

  localparam int NUM_PAGES = 32768;
  localparam int COUNT_BITS = 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam page_t PAGE_MAX = '1;
  localparam int OWNED_KEEP = 48;

  typedef struct packed {
    page_t   result_page;
    status_t status;
    logic    page_released;
    logic    needs_copy;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite, pready;
  apb_addr_t paddr;
  logic [31:0] pwdata, prdata;

  rcpa_in_if req_if ();
  rcpa_out_if rsp_if ();

  refcounted_page_allocator_top #(
    .NUM_PAGES (NUM_PAGES),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_if),
    .rsp    (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #6 clk = ~clk;

  // allocator state as the block should hold it
  page_t                 first_usable;
  page_t                 free_stack [NUM_PAGES];
  logic [15:0]           stack_depth;
  logic [15:0]           fresh_limit;
  logic [COUNT_BITS-1:0] ref_count [NUM_PAGES];

  outcome_t pending_outcomes[$];
  page_t    owned_pages[$];
  int       errors;
  int       cmds_seen [4];
  int       status_seen [5];
  bit       no_idle;
  int       hold_request;

  function automatic bit pool_take(output page_t pg);
    if (stack_depth != 16'd0) begin
      stack_depth = stack_depth - 16'd1;
      pg = free_stack[stack_depth[14:0]];
    end else if (fresh_limit > {1'b0, first_usable}) begin
      fresh_limit = fresh_limit - 16'd1;
      pg = fresh_limit[14:0];
    end else begin
      pg = '0;
      return 1'b0;
    end
    ref_count[pg] = COUNT_BITS'(1);
    return 1'b1;
  endfunction

  function automatic void pool_return(input page_t pg);
    // a push onto a full stack is lost
    if (stack_depth < 16'(NUM_PAGES)) begin
      free_stack[stack_depth[14:0]] = pg;
      stack_depth = stack_depth + 16'd1;
    end
  endfunction

  function automatic outcome_t page_op_outcome(input cmd_t c, input page_t p);
    outcome_t o;
    page_t    pg;
    o = '0;
    o.status = ST_OK;
    if (c == CMD_ALLOC) begin
      if (pool_take(pg)) o.result_page = pg;
      else o.status = ST_EMPTY;
    end else if (p < first_usable) begin
      o.status = ST_RANGE;
    end else if (c == CMD_FREE) begin
      if (ref_count[p] == 0) begin
        o.status = ST_DOUBLE;
      end else begin
        ref_count[p] = ref_count[p] - 1'b1;
        if (ref_count[p] == 0) begin
          pool_return(p);
          o.page_released = 1'b1;
        end
      end
    end else if (c == CMD_ADD_REF) begin
      if (ref_count[p] == COUNT_MAX) o.status = ST_SAT;
      else ref_count[p] = ref_count[p] + 1'b1;
    end else begin
      if (ref_count[p] == 0) begin
        o.status = ST_DOUBLE;
      end else if (ref_count[p] == 1) begin
        o.result_page = p;
      end else if (pool_take(pg)) begin
        // taking first matters when the new page is the old one
        ref_count[p] = ref_count[p] - 1'b1;
        o.result_page = pg;
        o.needs_copy = 1'b1;
      end else begin
        o.status = ST_EMPTY;
      end
    end
    return o;
  endfunction

  function automatic void track_owned(input cmd_t c, input page_t p, input outcome_t o);
    if (o.status == ST_OK && (c == CMD_ALLOC || o.needs_copy)) begin
      owned_pages.push_back(o.result_page);
      if (owned_pages.size() > OWNED_KEEP) void'(owned_pages.pop_front());
    end
    if (o.page_released) begin
      for (int i = owned_pages.size() - 1; i >= 0; i--) begin
        if (owned_pages[i] == p) owned_pages.delete(i);
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one request beat; returns what the block should answer
  task automatic send_cmd(input cmd_t c, input page_t p, output outcome_t o);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= c;
    req_if.page <= p;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    o = page_op_outcome(c, p);
    pending_outcomes.push_back(o);
    track_owned(c, p, o);
    cmds_seen[c]++;
    status_seen[o.status]++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] wdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_FIRST_USABLE;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr) begin
      first_usable = wdata[14:0];
    end else if (prdata !== {17'd0, first_usable}) begin
      $error("first_usable_page readback: expected %0d, actual %0d", first_usable, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_first_usable(input logic [31:0] value);
    drain_results();
    apb_access(1'b1, value);
    apb_access(1'b0, '0);
  endtask

  // result checking
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result beat with nothing expected: page %0d status %0d",
               rsp_if.result_page, rsp_if.status);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp_if.result_page !== want.result_page) begin
          $error("result_page: expected %0d, actual %0d", want.result_page, rsp_if.result_page);
          errors++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.page_released !== want.page_released) begin
          $error("page_released: expected %0b, actual %0b", want.page_released,
                 rsp_if.page_released);
          errors++;
        end
        if (rsp_if.needs_copy !== want.needs_copy) begin
          $error("needs_copy: expected %0b, actual %0b", want.needs_copy, rsp_if.needs_copy);
          errors++;
        end
      end
    end
  end

  // result side: random stalls plus an occasional long hold-off
  int stall_left;
  int hold_left;
  always @(negedge clk) begin
    int r;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else if (no_idle) begin
      rsp_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else begin
      r = $urandom_range(99);
      if (r < 70) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b0;
        stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 50);
      end
    end
  end

  task automatic test_register_access();
    apb_access(1'b0, '0);
    set_first_usable(32'd0);
  endtask

  task automatic test_directed_commands();
    outcome_t o;
    page_t    a, b, c;
    send_cmd(CMD_ALLOC, PAGE_MAX, o);
    a = o.result_page;
    send_cmd(CMD_ALLOC, '0, o);
    b = o.result_page;
    send_cmd(CMD_ADD_REF, a, o);
    send_cmd(CMD_COW, a, o);            // shared: fresh copy
    c = o.result_page;
    send_cmd(CMD_COW, b, o);            // sole owner keeps the page
    send_cmd(CMD_FREE, c, o);
    send_cmd(CMD_ALLOC, '0, o);         // LIFO hands c back
    send_cmd(CMD_FREE, b, o);
    send_cmd(CMD_FREE, b, o);           // double free
    send_cmd(CMD_COW, b, o);            // release of unowned page
    send_cmd(CMD_ADD_REF, '0, o);       // reference to a free page
    send_cmd(CMD_FREE, '0, o);
    send_cmd(CMD_ALLOC, '0, o);
    send_cmd(CMD_FREE, '0, o);
  endtask

  task automatic test_empty_pool();
    outcome_t o;
    // upper bits of the write are dropped
    set_first_usable(32'hFFFF_FFFF);
    // stacked pages below the new floor are still served
    while (stack_depth != 0 || fresh_limit > {1'b0, first_usable})
      send_cmd(CMD_ALLOC, '0, o);
    send_cmd(CMD_ALLOC, '0, o);
    send_cmd(CMD_ADD_REF, PAGE_MAX, o);
    send_cmd(CMD_ADD_REF, PAGE_MAX, o);
    send_cmd(CMD_COW, PAGE_MAX, o);     // copy needed, none left
    send_cmd(CMD_FREE, '0, o);
    send_cmd(CMD_ADD_REF, PAGE_MAX - 1'b1, o);
    send_cmd(CMD_COW, page_t'(100), o);
    while (ref_count[PAGE_MAX] != 0) send_cmd(CMD_FREE, PAGE_MAX, o);
    send_cmd(CMD_ALLOC, '0, o);
  endtask

  task automatic test_saturation();
    outcome_t o;
    page_t    p;
    set_first_usable(32'd32700);
    send_cmd(CMD_ALLOC, '0, o);
    p = o.result_page;
    if (o.status == ST_OK) begin
      no_idle = 1'b1;
      repeat (int'(COUNT_MAX)) send_cmd(CMD_ADD_REF, p, o);  // last one saturates
      no_idle = 1'b0;
      repeat (int'(COUNT_MAX)) send_cmd(CMD_FREE, p, o);
      send_cmd(CMD_FREE, p, o);
    end
  endtask

  task automatic test_backpressure();
    outcome_t o;
    drain_results();
    no_idle = 1'b1;
    hold_request = 400;
    for (int i = 0; i < 16; i++) begin
      if (i % 3 == 2 && owned_pages.size() != 0) send_cmd(CMD_FREE, owned_pages[0], o);
      else send_cmd(CMD_ALLOC, page_t'($urandom_range(32767)), o);
    end
    no_idle = 1'b0;
    // sender waits for every outstanding result before going on
    drain_results();
  endtask

  task automatic test_random_traffic(input logic [31:0] floor, input bit steady, input int n);
    outcome_t o;
    cmd_t     c;
    page_t    p;
    int       r;
    set_first_usable(floor);
    no_idle = steady;
    repeat (n) begin
      r = $urandom_range(99);
      p = page_t'($urandom_range(32767));
      if (r < 30) begin
        c = CMD_ALLOC;
      end else if (r < 85 && owned_pages.size() != 0) begin
        p = owned_pages[$urandom_range(owned_pages.size() - 1)];
        c = (r < 55) ? CMD_FREE : (r < 70) ? CMD_ADD_REF : CMD_COW;
      end else begin
        c = cmd_t'($urandom_range(3));
        if (r < 92) p = page_t'($urandom_range(32767, first_usable - (first_usable != 0)));
      end
      send_cmd(c, p, o);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.cmd = CMD_ALLOC;
    req_if.page = '0;
    rsp_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_FIRST_USABLE;
    pwdata = '0;
    errors = 0;
    no_idle = 1'b0;
    hold_request = 0;
    first_usable = '0;
    stack_depth = '0;
    fresh_limit = 16'(NUM_PAGES);
    foreach (ref_count[i]) ref_count[i] = '0;
    foreach (free_stack[i]) free_stack[i] = '0;
    foreach (cmds_seen[i]) cmds_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_access();
    test_directed_commands();
    test_empty_pool();
    test_saturation();
    test_backpressure();
    test_random_traffic(32'd32704, 1'b0, 280);
    test_random_traffic(32'($urandom_range(32600, 32750)), 1'b1, 280);
    test_random_traffic(32'd0, 1'b0, 280);
    test_random_traffic(32'd32740, 1'b0, 280);
    drain_results();

    $display("commands: alloc %0d, free %0d, add-ref %0d, cow release %0d",
             cmds_seen[CMD_ALLOC], cmds_seen[CMD_FREE], cmds_seen[CMD_ADD_REF],
             cmds_seen[CMD_COW]);
    $display("outcomes: ok %0d, pool empty %0d, out of range %0d, double free %0d, saturated %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
             status_seen[ST_DOUBLE], status_seen[ST_SAT]);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
